// ===== src/pidaw_pkg.sv =====
// Shared constants, types and helpers for the anti-windup PID controller.
package pidaw_pkg;

    // Fixed point format and field widths
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 31;
    localparam int REG_IDX_W  = 3;

    // Digit-serial multiplier geometry
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = DATA_W / DIGIT_W;
    localparam int DCNT_W     = $clog2(NUM_DIGITS);
    localparam int ACC_HI_W   = DATA_W + DIGIT_W + 1;
    localparam int PROD_W     = 2 * DATA_W;

    // Configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_TARGET      = 3'd3,
        REG_DRIVE_MIN   = 3'd4,
        REG_DRIVE_MAX   = 3'd5,
        REG_SAMPLE_PER  = 3'd6,
        REG_INTEG_LIMIT = 3'd7
    } reg_idx_t;

    // Input action codes
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_RESET  = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIFF,
        ST_MUL_P,
        ST_MUL_S,
        ST_INTEG,
        ST_ILIM,
        ST_MUL_I,
        ST_MUL_D,
        ST_SUM1,
        ST_SUM2,
        ST_CLAMP,
        ST_OUT
    } state_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] gain;
        logic [DATA_W-1:0] value;
    } mul_req_t;

    // Status back from the shared multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    // Saturate a 34-bit signed value to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W-1:0] r;
        if ((v[DATA_W+1:DATA_W-1] == 3'b000) || (v[DATA_W+1:DATA_W-1] == 3'b111)) begin
            r = v[DATA_W-1:0];
        end else if (v[DATA_W+1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== src/pidaw_mul.sv =====
// Digit-serial multiplier: unsigned gain times signed value, scaled and saturated.
module pidaw_mul (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pidaw_pkg::mul_req_t      req,
    output pidaw_pkg::mul_stat_t     stat,
    output logic [pidaw_pkg::DATA_W-1:0] result
);
    import pidaw_pkg::*;

    localparam int TOP_W = PROD_W - FRAC_BITS - DATA_W + 1;

    logic [DATA_W-1:0]          gain_sr_reg;
    logic signed [DATA_W-1:0]   val_reg;
    logic signed [ACC_HI_W-1:0] hi_reg;
    logic [DATA_W-1:0]          lo_reg;
    logic [DCNT_W-1:0]          cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic signed [ACC_HI_W-1:0] pp;
    logic signed [ACC_HI_W-1:0] step_sum;
    logic [PROD_W-1:0]          prod;
    logic [TOP_W-1:0]           prod_top;

    // One digit of the gain times the value, added into the running upper half
    assign pp       = $signed({{(ACC_HI_W-DIGIT_W){1'b0}}, gain_sr_reg[DIGIT_W-1:0]})
                    * $signed({{(ACC_HI_W-DATA_W){val_reg[DATA_W-1]}}, val_reg});
    assign step_sum = hi_reg + pp;

    // Digit loop: the low digit of each partial sum shifts into the low half
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(NUM_DIGITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            gain_sr_reg <= {{DIGIT_W{1'b0}}, gain_sr_reg[DATA_W-1:DIGIT_W]};
            hi_reg      <= step_sum >>> DIGIT_W;
            lo_reg      <= {step_sum[DIGIT_W-1:0], lo_reg[DATA_W-1:DIGIT_W]};
        end else if (req.start) begin
            gain_sr_reg <= {1'b0, req.gain};
            val_reg     <= $signed(req.value);
            hi_reg      <= '0;
            lo_reg      <= '0;
        end
    end

    // Full product; the upper half has settled into 32 bits by the last digit
    assign prod     = {hi_reg[DATA_W-1:0], lo_reg};
    assign prod_top = prod[PROD_W-1:FRAC_BITS+DATA_W-1];

    // Floor shift by the fraction width, then saturate to 32 bits
    always_comb begin
        if ((prod_top == '0) || (prod_top == '1)) begin
            result = prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
        end else if (prod[PROD_W-1]) begin
            result = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            result = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    // A start request while busy would be lost
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.start)
        else $error("multiplier started while busy");

    // Done follows exactly the last digit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (cnt_reg == DCNT_W'(NUM_DIGITS - 1))) |=> (done_reg && !busy_reg))
        else $error("multiplier did not finish after its last digit");

    // Done and busy never overlap
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(done_reg && busy_reg))
        else $error("multiplier done while still busy");

endmodule

// ===== src/pid_controller_anti_windup_core.sv =====
// Top level of the anti-windup PID controller with its sequencer and datapath.
//
// Input beats carry the measurement in s_tdata and the action flag in s_tuser:
// 0 runs one control update, 1 clears the integrator and the error history and
// answers with drive_min. Every input beat gives exactly one output beat on the
// m_ channel with the clamped drive value.
// An update steps from acceptance to m_tvalid through the error and its
// difference, four products on one shared digit-serial multiplier (4 gain
// bits per cycle, 8 digits), the integral add and clamp, the two sums, the
// output clamp and the load of the output register. A reset action goes
// straight to the load of the output register.
// The next input beat is accepted in the cycle after the result has been loaded
// into the output register; no new beat is taken while an update is in progress.
// If the receiver stalls, the finished result waits in the output register and
// the block still accepts and works on the next beat; it holds that beat's result
// until the output register is free.
// Registers are written through cfg_wr_en, cfg_addr and cfg_wdata; the user must write them only while
// the block is idle, as the block does not enforce this. Reset (aresetn low, synchronous) restores the
// register defaults, clears the integrator and the error history and drops m_tvalid.
module pid_controller_anti_windup_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [pidaw_pkg::REG_IDX_W-1:0]   cfg_addr,
    input  logic [pidaw_pkg::DATA_W-1:0]      cfg_wdata,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pidaw_pkg::DATA_W-1:0]      s_tdata,   // [31:0] measured
    input  logic                              s_tuser,   // [0] action
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pidaw_pkg::DATA_W-1:0]      m_tdata    // [31:0] drive
);
    import pidaw_pkg::*;

    // Configuration registers
    logic [GAIN_W-1:0]        prop_gain_reg;
    logic [GAIN_W-1:0]        integ_gain_reg;
    logic [GAIN_W-1:0]        deriv_gain_reg;
    logic signed [DATA_W-1:0] target_reg;
    logic signed [DATA_W-1:0] drive_min_reg;
    logic signed [DATA_W-1:0] drive_max_reg;
    logic [GAIN_W-1:0]        sample_per_reg;
    logic [GAIN_W-1:0]        integ_limit_reg;

    // Controller state
    logic signed [DATA_W-1:0] integ_acc_reg;
    logic signed [DATA_W-1:0] last_err_reg;

    // Working registers for one update
    state_t                   state_reg, state_next;
    logic signed [DATA_W-1:0] meas_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] diff_reg;
    logic signed [DATA_W-1:0] p_term_reg;
    logic signed [DATA_W-1:0] s_prod_reg;
    logic signed [DATA_W-1:0] integ_reg;
    logic signed [DATA_W-1:0] i_term_reg;
    logic signed [DATA_W-1:0] d_term_reg;
    logic signed [DATA_W:0]   sum_pi_reg;
    logic signed [DATA_W-1:0] sum_reg;
    logic signed [DATA_W-1:0] drive_reg;

    // Output register
    logic                     m_valid_reg;
    logic [DATA_W-1:0]        m_data_reg;

    // Multiplier connection
    mul_req_t                 mul_req;
    mul_stat_t                mul_stat;
    logic [DATA_W-1:0]        mul_res;
    logic                     in_mul_state;

    logic                     s_accept;
    logic                     out_free;
    logic signed [DATA_W+1:0] lim_ext;
    logic signed [DATA_W-1:0] clamp_hi;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign lim_ext  = $signed({3'b000, integ_limit_reg});
    assign clamp_hi = (sum_reg > drive_max_reg) ? drive_max_reg : sum_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= GAIN_W'(327680);
            integ_gain_reg  <= GAIN_W'(32768);
            deriv_gain_reg  <= GAIN_W'(2185);
            target_reg      <= DATA_W'(1638400);
            drive_min_reg   <= '0;
            drive_max_reg   <= DATA_W'(6553600);
            sample_per_reg  <= GAIN_W'(1966080);
            integ_limit_reg <= GAIN_W'(13081038);
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_TARGET:      target_reg      <= $signed(cfg_wdata);
                REG_DRIVE_MIN:   drive_min_reg   <= $signed(cfg_wdata);
                REG_DRIVE_MAX:   drive_max_reg   <= $signed(cfg_wdata);
                REG_SAMPLE_PER:  sample_per_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_LIMIT: integ_limit_reg <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser == ACT_RESET) ? ST_OUT : ST_ERR;
                end
            end
            ST_ERR:   state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MUL_P;
            ST_MUL_P: if (mul_stat.done) state_next = ST_MUL_S;
            ST_MUL_S: if (mul_stat.done) state_next = ST_INTEG;
            ST_INTEG: state_next = ST_ILIM;
            ST_ILIM:  state_next = ST_MUL_I;
            ST_MUL_I: if (mul_stat.done) state_next = ST_MUL_D;
            ST_MUL_D: if (mul_stat.done) state_next = ST_SUM1;
            ST_SUM1:  state_next = ST_SUM2;
            ST_SUM2:  state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: input ready and multiplier operands
    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        in_mul_state  = 1'b1;
        mul_req.gain  = prop_gain_reg;
        mul_req.value = err_reg;
        case (state_reg)
            ST_MUL_P: begin
                mul_req.gain  = prop_gain_reg;
                mul_req.value = err_reg;
            end
            ST_MUL_S: begin
                mul_req.gain  = sample_per_reg;
                mul_req.value = err_reg;
            end
            ST_MUL_I: begin
                mul_req.gain  = integ_gain_reg;
                mul_req.value = integ_reg;
            end
            ST_MUL_D: begin
                mul_req.gain  = deriv_gain_reg;
                mul_req.value = diff_reg;
            end
            default: in_mul_state = 1'b0;
        endcase
        mul_req.start = in_mul_state && !mul_stat.busy && !mul_stat.done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    pidaw_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .stat    (mul_stat),
        .result  (mul_res)
    );

    // Controller history: cleared by reset or a reset action, committed per update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_acc_reg <= '0;
            last_err_reg  <= '0;
        end else if (s_accept && (s_tuser == ACT_RESET)) begin
            integ_acc_reg <= '0;
            last_err_reg  <= '0;
        end else if (state_reg == ST_SUM2) begin
            integ_acc_reg <= integ_reg;
            last_err_reg  <= err_reg;
        end
    end

    // Datapath, one step per state
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                meas_reg  <= $signed(s_tdata);
                drive_reg <= drive_min_reg;
            end
            ST_ERR: begin
                err_reg <= sat32(34'(target_reg) - 34'(meas_reg));
            end
            ST_DIFF: begin
                diff_reg <= sat32(34'(err_reg) - 34'(last_err_reg));
            end
            ST_MUL_P: if (mul_stat.done) p_term_reg <= $signed(mul_res);
            ST_MUL_S: if (mul_stat.done) s_prod_reg <= $signed(mul_res);
            ST_INTEG: begin
                integ_reg <= sat32(34'(integ_acc_reg) + 34'(s_prod_reg));
            end
            ST_ILIM: begin
                // Symmetric integral clamp
                if (34'(integ_reg) > lim_ext) begin
                    integ_reg <= $signed({1'b0, integ_limit_reg});
                end else if (34'(integ_reg) < -lim_ext) begin
                    integ_reg <= DATA_W'(-lim_ext);
                end
            end
            ST_MUL_I: if (mul_stat.done) i_term_reg <= $signed(mul_res);
            ST_MUL_D: if (mul_stat.done) d_term_reg <= $signed(mul_res);
            ST_SUM1: begin
                sum_pi_reg <= 33'(p_term_reg) + 33'(i_term_reg);
            end
            ST_SUM2: begin
                sum_reg <= sat32(34'(sum_pi_reg) + 34'(d_term_reg));
            end
            ST_CLAMP: begin
                // Upper bound first, lower bound wins when the bounds cross
                drive_reg <= (clamp_hi < drive_min_reg) ? drive_min_reg : clamp_hi;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_OUT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_OUT) && out_free) begin
            m_data_reg <= drive_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A reset action answers with the lower bound and cleared history
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tuser == ACT_RESET)) |=>
            ((state_reg == ST_OUT) && (drive_reg == drive_min_reg) &&
             (integ_acc_reg == '0) && (last_err_reg == '0)))
        else $error("reset action did not clear history or load drive_min");

    // After the clamp step the integral lies within the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ILIM) |=>
            ((34'(integ_reg) <= lim_ext) && (34'(integ_reg) >= -lim_ext)))
        else $error("integral outside its clamp");

    // The multiplier only reports a product in a state that consumes it
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.done |-> ((state_reg == ST_MUL_P) || (state_reg == ST_MUL_S) ||
                           (state_reg == ST_MUL_I) || (state_reg == ST_MUL_D)))
        else $error("product finished outside a multiply step");

endmodule

// ===== tb/pid_controller_anti_windup_core_tb.sv =====
// Self-checking testbench for the anti-windup PID controller core.
module pid_controller_anti_windup_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pidaw_pkg::*;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam int     MAX_REPORTS = 10;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_addr  = '0;
    logic [DATA_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata   = '0;   // [31:0] measured
    logic                 s_tuser   = 1'b0;  // [0] action
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DATA_W-1:0]    m_tdata;           // [31:0] drive

    // Controller shadow: register file, integrator and error history
    logic [31:0] ctl_regs [8];
    int          integ_state;
    int          err_hist;

    // Drive values predicted for accepted samples, oldest first
    logic [31:0] expected_drive [$];

    int send_idle_pct = 27;
    int recv_idle_pct = 53;
    int samples_sent;
    int drives_checked;
    int reg_sets_loaded;
    int fail_count;

    pid_controller_anti_windup_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #10_000_000;
        $display("pid_controller_anti_windup_core regression: fail");
        $finish;
    end

    // Saturate a wide value to the signed 32-bit range.
    function automatic int clamp_s32(input longint v);
        if (v > S32_MAX) return 32'h7FFF_FFFF;
        if (v < S32_MIN) return 32'h8000_0000;
        return int'(v);
    endfunction

    // Unsigned Q15.16 gain times a signed value, floored and saturated.
    function automatic int gain_mul(input logic [31:0] gain_word, input int v);
        longint prod;
        prod = longint'(gain_word[30:0]) * longint'(v);
        return clamp_s32(prod >>> FRAC_BITS);
    endfunction

    // Advance the controller shadow by one sample and return its drive.
    function automatic logic [31:0] next_drive(input logic act, input logic [31:0] meas);
        int     meas_v, tgt, lo, hi;
        int     err, p_part, i_part, d_part;
        longint integ_wide, lim, total;
        meas_v = meas;
        tgt    = ctl_regs[REG_TARGET];
        lo     = ctl_regs[REG_DRIVE_MIN];
        hi     = ctl_regs[REG_DRIVE_MAX];
        if (act == ACT_RESET) begin
            integ_state = 0;
            err_hist    = 0;
            return ctl_regs[REG_DRIVE_MIN];
        end
        err    = clamp_s32(longint'(tgt) - longint'(meas_v));
        p_part = gain_mul(ctl_regs[REG_PROP_GAIN], err);

        // Integrate, then hold the accumulator inside the symmetric limit.
        integ_wide = clamp_s32(longint'(integ_state)
                               + longint'(gain_mul(ctl_regs[REG_SAMPLE_PER], err)));
        lim = longint'(ctl_regs[REG_INTEG_LIMIT][30:0]);
        if (integ_wide > lim) integ_wide = lim;
        if (integ_wide < -lim) integ_wide = -lim;
        i_part = gain_mul(ctl_regs[REG_INTEG_GAIN], int'(integ_wide));

        d_part = gain_mul(ctl_regs[REG_DERIV_GAIN],
                          clamp_s32(longint'(err) - longint'(err_hist)));
        integ_state = int'(integ_wide);
        err_hist    = err;

        // Upper bound first, lower bound last, so inverted bounds give drive_min.
        total = clamp_s32(longint'(p_part) + longint'(i_part) + longint'(d_part));
        if (total > longint'(hi)) total = hi;
        if (total < longint'(lo)) total = lo;
        return total[31:0];
    endfunction

    // Receiver: stall at random at the current rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare every result beat with the oldest predicted drive.
    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_drive.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result beat: drive %0d (0x%08h)",
                             $signed(m_tdata), m_tdata);
            end else begin
                want = expected_drive.pop_front();
                drives_checked++;
                if (m_tdata !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("drive mismatch on result %0d: expected %0d (0x%08h), got %0d (0x%08h)",
                                 drives_checked, $signed(want), want, $signed(m_tdata), m_tdata);
                end
            end
        end
    end

    // Send one sample beat; valid stays high into the next beat unless a gap is drawn.
    task automatic send_sample(input logic act, input logic [31:0] meas);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= meas;
        s_tuser  <= act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_drive.push_back(next_drive(act, meas));
        samples_sent++;
    endtask

    // Stop sending and wait until every predicted drive has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_drive.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all eight registers while the block is idle and mirror them.
    task automatic reprogram(input logic [31:0] kp, input logic [31:0] ki,
                             input logic [31:0] kd_dt, input logic [31:0] tgt,
                             input logic [31:0] lo, input logic [31:0] hi,
                             input logic [31:0] per, input logic [31:0] lim);
        logic [31:0] vals [8];
        reg_idx_t    idx;
        vals[REG_PROP_GAIN]   = kp;
        vals[REG_INTEG_GAIN]  = ki;
        vals[REG_DERIV_GAIN]  = kd_dt;
        vals[REG_TARGET]      = tgt;
        vals[REG_DRIVE_MIN]   = lo;
        vals[REG_DRIVE_MAX]   = hi;
        vals[REG_SAMPLE_PER]  = per;
        vals[REG_INTEG_LIMIT] = lim;
        drain_results();
        for (int i = 0; i < 8; i++) begin
            idx = reg_idx_t'(i);
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= vals[i];
            @(posedge aclk);
            if (idx == REG_TARGET || idx == REG_DRIVE_MIN || idx == REG_DRIVE_MAX)
                ctl_regs[i] = vals[i];
            else
                ctl_regs[i] = {1'b0, vals[i][30:0]};
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        reg_sets_loaded++;
    endtask

    // Register value: mostly a plausible magnitude, sometimes anything, sometimes an edge.
    function automatic logic [31:0] pick_reg_word(input int typical_hi, input bit may_be_neg);
        logic [31:0] w;
        int          r;
        r = $urandom_range(0, 15);
        if (r < 11) begin
            w = $urandom_range(0, typical_hi);
            if (may_be_neg && $urandom_range(0, 1)) w = -w;
        end else if (r < 14) begin
            w = $urandom;
        end else begin
            case ($urandom_range(0, 3))
                0:       w = 32'h0000_0000;
                1:       w = 32'h7FFF_FFFF;
                2:       w = 32'h8000_0000;
                default: w = 32'hFFFF_FFFF;
            endcase
        end
        return w;
    endfunction

    // Default registers straight after reset, plus the reset action.
    task automatic test_default_regs();
        send_sample(ACT_UPDATE, 32'h0000_0000);
        send_sample(ACT_UPDATE, 32'd1638400);
        send_sample(ACT_UPDATE, 32'h7FFF_FFFF);
        send_sample(ACT_UPDATE, 32'h8000_0000);
        send_sample(ACT_RESET, $urandom);
        send_sample(ACT_UPDATE, 32'h0010_0000);
    endtask

    // Saturation at every stage, zero gains, inverted bounds and floor rounding.
    task automatic test_extreme_regs();
        // Full-scale gains and period; error and error difference both saturate.
        reprogram(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(ACT_UPDATE, 32'h8000_0000);
        send_sample(ACT_UPDATE, 32'h7FFF_FFFF);
        send_sample(ACT_UPDATE, 32'h8000_0000);
        send_sample(ACT_UPDATE, 32'h0000_0000);
        send_sample(ACT_RESET, 32'hFFFF_FFFF);

        // Zero gains and a zero integral limit.
        reprogram(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_sample(ACT_UPDATE, 32'h8000_0000);
        send_sample(ACT_UPDATE, 32'hFFFF_FFFF);

        // Inverted output bounds.
        reprogram(32'd327680, 32'd32768, 32'd2185, 32'd1638400,
                  32'd6553600, -32'sd6553600, 32'd1966080, 32'd13081038);
        send_sample(ACT_UPDATE, 32'h0000_0000);
        send_sample(ACT_UPDATE, 32'd9830400);
        send_sample(ACT_RESET, 32'h0000_0000);

        // Tiny gains: negative products must round toward minus infinity.
        reprogram(32'd1, 32'd1, 32'd1, 32'h0000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd5);
        send_sample(ACT_UPDATE, 32'd1);
        send_sample(ACT_UPDATE, 32'd1);
        send_sample(ACT_UPDATE, 32'hFFFF_FFFF);
    endtask

    // Random register sets, each followed by a burst of mostly tracking samples.
    task automatic test_random_stream(input int tx_idle, input int rx_idle, input int n_items);
        int          left, burst, r;
        int          drift;
        logic [31:0] lo, hi, swap_w, meas;
        logic        act;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        left = n_items;
        while (left > 0) begin
            lo = pick_reg_word(200 << 16, 1'b1);
            hi = pick_reg_word(200 << 16, 1'b1);
            // Keep the bounds ordered most of the time.
            if ($signed(lo) > $signed(hi) && $urandom_range(0, 3) != 0) begin
                swap_w = lo;
                lo     = hi;
                hi     = swap_w;
            end
            reprogram(pick_reg_word(8 << 16, 1'b0), pick_reg_word(4 << 16, 1'b0),
                      pick_reg_word(2 << 16, 1'b0), pick_reg_word(200 << 16, 1'b1),
                      lo, hi, pick_reg_word(64 << 16, 1'b0),
                      pick_reg_word(1000 << 16, 1'b0));
            burst = $urandom_range(20, 50);
            if (burst > left) burst = left;
            drift = $urandom_range(0, 64 << 16) - (32 << 16);
            repeat (burst) begin
                r   = $urandom_range(0, 99);
                act = ACT_UPDATE;
                if (r < 6) begin
                    act  = ACT_RESET;
                    meas = $urandom;
                end else if (r < 14) begin
                    meas = $urandom;
                end else if (r < 18) begin
                    meas = ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
                end else begin
                    // Process value wandering around the setpoint.
                    drift = drift + $urandom_range(0, 8 << 16) - (4 << 16);
                    if (drift > (256 << 16)) drift = 256 << 16;
                    if (drift < -(256 << 16)) drift = -(256 << 16);
                    meas = clamp_s32(longint'($signed(ctl_regs[REG_TARGET]))
                                     + longint'(drift));
                end
                send_sample(act, meas);
                left--;
            end
        end
    endtask

    // Test sequence.
    initial begin
        for (int i = 0; i < 8; i++) ctl_regs[i] = '0;
        ctl_regs[REG_PROP_GAIN]   = 32'd327680;
        ctl_regs[REG_INTEG_GAIN]  = 32'd32768;
        ctl_regs[REG_DERIV_GAIN]  = 32'd2185;
        ctl_regs[REG_TARGET]      = 32'd1638400;
        ctl_regs[REG_DRIVE_MIN]   = 32'd0;
        ctl_regs[REG_DRIVE_MAX]   = 32'd6553600;
        ctl_regs[REG_SAMPLE_PER]  = 32'd1966080;
        ctl_regs[REG_INTEG_LIMIT] = 32'd13081038;
        integ_state = 0;
        err_hist    = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_regs();
        test_extreme_regs();
        test_random_stream(27, 53, 216);
        test_random_stream(53, 27, 216);
        test_random_stream(0, 0, 218);

        drain_results();
        repeat (60) @(posedge aclk);
        fail_count += expected_drive.size();

        $display("Sent %0d sample beats over %0d register sets; checked %0d drive beats.",
                 samples_sent, reg_sets_loaded, drives_checked);
        $display("Mismatches and stray beats: %0d.", fail_count);
        if (fail_count == 0)
            $display("pid_controller_anti_windup_core regression: pass");
        else
            $display("pid_controller_anti_windup_core regression: fail");
        $finish;
    end

endmodule
